>>> hdl/ismap_pkg.sv
`default_nettype none
package ismap_pkg;

   localparam int SECTOR_BYTES      = 128;
   localparam int DIRECT_SLOTS      = 8;
   localparam int ENTRIES_PER_INDEX = 32;
   localparam int INDEX_BLOCKS      = 4;
   localparam int DISK_SECTORS      = 1024;

   localparam int MAX_SECTORS = DIRECT_SLOTS + INDEX_BLOCKS * ENTRIES_PER_INDEX;
   localparam int MAX_BYTES   = MAX_SECTORS * SECTOR_BYTES;

   localparam int FUNC_W   = 2;
   localparam int BYTES_W  = 15;
   localparam int COUNT_W  = 8;
   localparam int STATUS_W = 3;
   localparam int SECTOR_W = $clog2(DISK_SECTORS);

   localparam int SB_SHIFT  = $clog2(SECTOR_BYTES);
   localparam int EPI_SHIFT = $clog2(ENTRIES_PER_INDEX);
   localparam int MAP_AW    = $clog2(MAX_SECTORS);
   localparam int PTR_AW    = (INDEX_BLOCKS > 1) ? $clog2(INDEX_BLOCKS) : 1;
   localparam int WALK_W    = $clog2(MAX_SECTORS + INDEX_BLOCKS + 1);
   localparam int SUM_W     = COUNT_W + 1;
   localparam int FREE_W    = $clog2(DISK_SECTORS + 1);

   // bitmap is stored as words of BM_WORD_BITS
   localparam int BM_WORD_BITS = 32;
   localparam int BM_BIT_W     = $clog2(BM_WORD_BITS);
   localparam int BM_WORDS     = DISK_SECTORS / BM_WORD_BITS;
   localparam int BM_WA_W      = SECTOR_W - BM_BIT_W;

   localparam logic [FUNC_W-1:0] FN_ALLOCATE  = 2'd0;
   localparam logic [FUNC_W-1:0] FN_EXTEND    = 2'd1;
   localparam logic [FUNC_W-1:0] FN_RELEASE   = 2'd2;
   localparam logic [FUNC_W-1:0] FN_TRANSLATE = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CORRUPT      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd4;

   typedef struct packed {
      logic                take;
      logic                test;
      logic                clear;
      logic [SECTOR_W-1:0] sector;
   } bm_cmd_type;

   typedef struct packed {
      logic                done;
      logic                used;
      logic [SECTOR_W-1:0] sector;
   } bm_rsp_type;

   // index blocks needed to hold n data sectors
   function automatic logic [SUM_W-1:0] blocks_for(input logic [SUM_W-1:0] n);
      logic [SUM_W-1:0] t;
      t = n - SUM_W'(DIRECT_SLOTS) + SUM_W'(ENTRIES_PER_INDEX - 1);
      if (n <= SUM_W'(DIRECT_SLOTS)) begin
         return '0;
      end
      return t >> EPI_SHIFT;
   endfunction

endpackage
`default_nettype wire

>>> hdl/ismap_bitmap.sv
`default_nettype none
module ismap_bitmap (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ismap_pkg::bm_cmd_type         cmd,
   output ismap_pkg::bm_rsp_type              rsp,
   output logic [ismap_pkg::FREE_W-1:0]       free_count
);

   typedef enum logic [1:0] {BM_IDLE, BM_TAKE, BM_TEST, BM_CLR} bm_state_type;

   bm_state_type                               state_ff;
   logic [ismap_pkg::BM_WORD_BITS-1:0]         mem [ismap_pkg::BM_WORDS];
   logic [ismap_pkg::BM_WORD_BITS-1:0]         rd_ff;
   logic [ismap_pkg::BM_WORDS-1:0]             full_ff;
   logic [ismap_pkg::BM_WORDS-1:0]             valid_ff;
   logic [ismap_pkg::BM_WA_W-1:0]              wa_ff;
   logic [ismap_pkg::BM_BIT_W-1:0]             bit_ff;
   logic [ismap_pkg::FREE_W-1:0]               free_ff;
   ismap_pkg::bm_rsp_type                      rsp_ff;

   logic [ismap_pkg::BM_WA_W-1:0]              open_wa;
   logic [ismap_pkg::BM_WA_W-1:0]              rd_addr;
   logic [ismap_pkg::BM_WORD_BITS-1:0]         word;
   logic [ismap_pkg::BM_BIT_W-1:0]             zero_bit;
   logic [ismap_pkg::BM_WORD_BITS-1:0]         set_word;
   logic [ismap_pkg::BM_WORD_BITS-1:0]         clr_word;
   logic                                       mem_we;
   logic [ismap_pkg::BM_WORD_BITS-1:0]         mem_wd;

   // lowest word with a free bit
   always_comb begin
      open_wa = '0;
      for (int i = ismap_pkg::BM_WORDS - 1; i >= 0; i--) begin
         if (!full_ff[i]) begin
            open_wa = ismap_pkg::BM_WA_W'(i);
         end
      end
   end

   assign rd_addr = cmd.take ? open_wa : cmd.sector[ismap_pkg::SECTOR_W-1:ismap_pkg::BM_BIT_W];
   // a word never written reads as all free
   assign word = valid_ff[wa_ff] ? rd_ff : '0;

   always_comb begin
      zero_bit = '0;
      for (int i = ismap_pkg::BM_WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            zero_bit = ismap_pkg::BM_BIT_W'(i);
         end
      end
   end

   assign set_word = word | (ismap_pkg::BM_WORD_BITS'(1) << zero_bit);
   assign clr_word = word & ~(ismap_pkg::BM_WORD_BITS'(1) << bit_ff);
   assign mem_we   = (state_ff == BM_TAKE) || (state_ff == BM_CLR);
   assign mem_wd   = (state_ff == BM_TAKE) ? set_word : clr_word;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wa_ff] <= mem_wd;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BM_IDLE;
         full_ff     <= '0;
         valid_ff    <= '0;
         free_ff     <= ismap_pkg::FREE_W'(ismap_pkg::DISK_SECTORS);
         rsp_ff.done <= 1'b0;
      end else begin
         rsp_ff.done <= 1'b0;
         case (state_ff)
            BM_IDLE: begin
               wa_ff  <= rd_addr;
               bit_ff <= cmd.sector[ismap_pkg::BM_BIT_W-1:0];
               if (cmd.take) begin
                  state_ff <= BM_TAKE;
               end else if (cmd.test) begin
                  state_ff <= BM_TEST;
               end else if (cmd.clear) begin
                  state_ff <= BM_CLR;
               end
            end
            BM_TAKE: begin
               full_ff[wa_ff]  <= &set_word;
               valid_ff[wa_ff] <= 1'b1;
               free_ff         <= free_ff - 1'b1;
               rsp_ff.sector   <= {wa_ff, zero_bit};
               rsp_ff.done     <= 1'b1;
               state_ff        <= BM_IDLE;
            end
            BM_TEST: begin
               rsp_ff.used <= word[bit_ff];
               rsp_ff.done <= 1'b1;
               state_ff    <= BM_IDLE;
            end
            BM_CLR: begin
               full_ff[wa_ff]  <= 1'b0;
               valid_ff[wa_ff] <= 1'b1;
               free_ff         <= free_ff + 1'b1;
               rsp_ff.done     <= 1'b1;
               state_ff        <= BM_IDLE;
            end
            default: state_ff <= BM_IDLE;
         endcase
      end
   end

   assign rsp        = rsp_ff;
   assign free_count = free_ff;

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.test, cmd.clear}))
      else $error("bitmap: more than one command");
   a_cmd_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.take || cmd.test || cmd.clear) |-> state_ff == BM_IDLE)
      else $error("bitmap: command while busy");
   a_free_range: assert property (@(posedge clock) disable iff (reset)
      free_ff <= ismap_pkg::FREE_W'(ismap_pkg::DISK_SECTORS))
      else $error("bitmap: free count overflow");

endmodule
`default_nettype wire

>>> hdl/inode_sector_map_engine_core.sv
`default_nettype none
// Sector map of one file. An operation is taken when start is high and busy low; exactly one
// result follows, shown for one cycle with rsp_valid, which cannot be held off. Allocate and extend
// take one bitmap sector per data sector and one more per new index block; release walks every
// mapped sector and index block twice (one check pass, one clear pass). Their pace is set by the
// free-bitmap unit, which serves one command (a test, or a read-modify-write of a 32-bit bitmap
// word) at a time.
module inode_sector_map_engine_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [ismap_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [ismap_pkg::BYTES_W-1:0]      req_byte_count,
   input  wire logic [ismap_pkg::COUNT_W-1:0]      req_sector_count,
   input  wire logic [ismap_pkg::BYTES_W-1:0]      req_byte_offset,
   output logic                                    rsp_valid,
   output logic [ismap_pkg::STATUS_W-1:0]          rsp_status,
   output logic [ismap_pkg::SECTOR_W-1:0]          rsp_sector,
   output logic [ismap_pkg::BYTES_W-1:0]           rsp_file_bytes,
   output logic [ismap_pkg::COUNT_W-1:0]           rsp_used_sectors
);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_APPEND, S_WAIT_PTR, S_WAIT_DATA, S_TR_OUT,
      S_RL_FETCH, S_RL_SEL, S_RL_WAIT
   } state_type;

   localparam int SW = ismap_pkg::SUM_W;

   state_type                              state_ff;
   logic [ismap_pkg::FUNC_W-1:0]           func_ff;
   logic [ismap_pkg::BYTES_W-1:0]          bytes_ff;
   logic [ismap_pkg::COUNT_W-1:0]          add_ff;
   logic [ismap_pkg::BYTES_W-1:0]          offset_ff;
   logic [ismap_pkg::COUNT_W-1:0]          mapped_ff;
   logic [ismap_pkg::BYTES_W-1:0]          length_ff;
   logic [ismap_pkg::COUNT_W-1:0]          target_ff;
   logic [ismap_pkg::WALK_W-1:0]           idx_ff;
   logic [ismap_pkg::WALK_W-1:0]           walk_end_ff;
   logic                                   pass_ff;
   logic                                   corrupt_ff;
   logic [ismap_pkg::SECTOR_W-1:0]         ptr_ff [ismap_pkg::INDEX_BLOCKS];
   logic [ismap_pkg::SECTOR_W-1:0]         map_mem [ismap_pkg::MAX_SECTORS];
   logic [ismap_pkg::SECTOR_W-1:0]         map_rd_ff;
   logic                                   rsp_valid_ff;
   logic [ismap_pkg::STATUS_W-1:0]         rsp_status_ff;
   logic [ismap_pkg::SECTOR_W-1:0]         rsp_sector_ff;
   ismap_pkg::bm_cmd_type                  bm_cmd_ff;
   ismap_pkg::bm_rsp_type                  bm_rsp;
   logic [ismap_pkg::FREE_W-1:0]           free_count;

   logic [ismap_pkg::BYTES_W:0]            bytes_round;
   logic [SW-1:0]                          n_alloc;
   logic [SW-1:0]                          alloc_need;
   logic [SW-1:0]                          ext_total;
   logic [SW:0]                            ext_need;
   logic [SW-1:0]                          nb_rel;
   logic [ismap_pkg::COUNT_W-1:0]          tr_m;
   logic [SW-1:0]                          rel_r;
   logic                                   new_block;
   logic [ismap_pkg::MAP_AW-1:0]           map_ra;
   logic                                   map_we;
   logic [ismap_pkg::WALK_W-1:0]           ptr_off;
   logic [ismap_pkg::SECTOR_W-1:0]         walk_sector;
   logic                                   too_large;

   assign bytes_round = (ismap_pkg::BYTES_W + 1)'(bytes_ff)
                      + (ismap_pkg::BYTES_W + 1)'(ismap_pkg::SECTOR_BYTES - 1);
   assign n_alloc     = SW'(bytes_round >> ismap_pkg::SB_SHIFT);
   assign alloc_need  = n_alloc + ismap_pkg::blocks_for(n_alloc);
   assign ext_total   = SW'(mapped_ff) + SW'(add_ff);
   assign ext_need    = (SW + 1)'(add_ff) + (SW + 1)'(ismap_pkg::blocks_for(ext_total))
                      - (SW + 1)'(ismap_pkg::blocks_for(SW'(mapped_ff)));
   assign nb_rel      = ismap_pkg::blocks_for(SW'(mapped_ff));
   assign tr_m        = ismap_pkg::COUNT_W'(offset_ff >> ismap_pkg::SB_SHIFT);
   assign too_large   = bytes_ff > ismap_pkg::BYTES_W'(ismap_pkg::MAX_BYTES);
   assign rel_r       = SW'(mapped_ff) - SW'(ismap_pkg::DIRECT_SLOTS);
   assign new_block   = (mapped_ff >= ismap_pkg::COUNT_W'(ismap_pkg::DIRECT_SLOTS))
                      && (rel_r[ismap_pkg::EPI_SHIFT-1:0] == '0);
   assign map_ra      = (state_ff == S_CHECK) ? tr_m[ismap_pkg::MAP_AW-1:0]
                                              : idx_ff[ismap_pkg::MAP_AW-1:0];
   assign map_we      = (state_ff == S_WAIT_DATA) && bm_rsp.done;
   assign ptr_off     = idx_ff - ismap_pkg::WALK_W'(mapped_ff);
   assign walk_sector = (idx_ff < ismap_pkg::WALK_W'(mapped_ff))
                      ? map_rd_ff : ptr_ff[ptr_off[ismap_pkg::PTR_AW-1:0]];

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[mapped_ff[ismap_pkg::MAP_AW-1:0]] <= bm_rsp.sector;
      end
      map_rd_ff <= map_mem[map_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mapped_ff    <= '0;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         bm_cmd_ff    <= '0;
      end else begin
         rsp_valid_ff    <= 1'b0;
         bm_cmd_ff.take  <= 1'b0;
         bm_cmd_ff.test  <= 1'b0;
         bm_cmd_ff.clear <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  func_ff   <= req_func;
                  bytes_ff  <= req_byte_count;
                  add_ff    <= req_sector_count;
                  offset_ff <= req_byte_offset;
                  state_ff  <= S_CHECK;
               end
            end
            S_CHECK: begin
               rsp_sector_ff <= '0;
               rsp_status_ff <= ismap_pkg::ST_OK;
               case (func_ff)
                  ismap_pkg::FN_ALLOCATE: begin
                     if (too_large) begin
                        rsp_status_ff <= ismap_pkg::ST_TOO_LARGE;
                        rsp_valid_ff  <= 1'b1;
                        state_ff      <= S_IDLE;
                     end else if (free_count < ismap_pkg::FREE_W'(alloc_need)) begin
                        rsp_status_ff <= ismap_pkg::ST_NO_SPACE;
                        rsp_valid_ff  <= 1'b1;
                        state_ff      <= S_IDLE;
                     end else begin
                        mapped_ff <= '0;
                        target_ff <= ismap_pkg::COUNT_W'(n_alloc);
                        state_ff  <= S_APPEND;
                     end
                  end
                  ismap_pkg::FN_EXTEND: begin
                     if (too_large) begin
                        rsp_status_ff <= ismap_pkg::ST_TOO_LARGE;
                        rsp_valid_ff  <= 1'b1;
                        state_ff      <= S_IDLE;
                     end else if ((ext_total > SW'(ismap_pkg::MAX_SECTORS))
                                  || ((ismap_pkg::FREE_W + 1)'(free_count)
                                      < (ismap_pkg::FREE_W + 1)'(ext_need))) begin
                        rsp_status_ff <= ismap_pkg::ST_NO_SPACE;
                        rsp_valid_ff  <= 1'b1;
                        state_ff      <= S_IDLE;
                     end else begin
                        target_ff <= ismap_pkg::COUNT_W'(ext_total);
                        state_ff  <= S_APPEND;
                     end
                  end
                  ismap_pkg::FN_RELEASE: begin
                     idx_ff      <= '0;
                     pass_ff     <= 1'b0;
                     corrupt_ff  <= 1'b0;
                     walk_end_ff <= ismap_pkg::WALK_W'(mapped_ff)
                                  + ismap_pkg::WALK_W'(nb_rel);
                     state_ff    <= S_RL_FETCH;
                  end
                  default: begin
                     if ((offset_ff >= length_ff) || (tr_m >= mapped_ff)) begin
                        rsp_status_ff <= ismap_pkg::ST_OUT_OF_RANGE;
                        rsp_valid_ff  <= 1'b1;
                        state_ff      <= S_IDLE;
                     end else begin
                        state_ff <= S_TR_OUT;
                     end
                  end
               endcase
            end
            S_TR_OUT: begin
               rsp_sector_ff <= map_rd_ff;
               rsp_valid_ff  <= 1'b1;
               state_ff      <= S_IDLE;
            end
            S_APPEND: begin
               if (mapped_ff == target_ff) begin
                  length_ff    <= bytes_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  bm_cmd_ff.take <= 1'b1;
                  state_ff       <= new_block ? S_WAIT_PTR : S_WAIT_DATA;
               end
            end
            S_WAIT_PTR: begin
               if (bm_rsp.done) begin
                  ptr_ff[ismap_pkg::PTR_AW'(rel_r >> ismap_pkg::EPI_SHIFT)] <= bm_rsp.sector;
                  bm_cmd_ff.take <= 1'b1;
                  state_ff       <= S_WAIT_DATA;
               end
            end
            S_WAIT_DATA: begin
               if (bm_rsp.done) begin
                  mapped_ff <= mapped_ff + 1'b1;
                  state_ff  <= S_APPEND;
               end
            end
            S_RL_FETCH: begin
               if (idx_ff == walk_end_ff) begin
                  if (!pass_ff) begin
                     if (corrupt_ff) begin
                        rsp_status_ff <= ismap_pkg::ST_CORRUPT;
                        rsp_valid_ff  <= 1'b1;
                        state_ff      <= S_IDLE;
                     end else begin
                        pass_ff <= 1'b1;
                        idx_ff  <= '0;
                     end
                  end else begin
                     mapped_ff    <= '0;
                     length_ff    <= '0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
               end else begin
                  state_ff <= S_RL_SEL;
               end
            end
            S_RL_SEL: begin
               bm_cmd_ff.sector <= walk_sector;
               bm_cmd_ff.test   <= !pass_ff;
               bm_cmd_ff.clear  <= pass_ff;
               state_ff         <= S_RL_WAIT;
            end
            S_RL_WAIT: begin
               if (bm_rsp.done) begin
                  if (!pass_ff && !bm_rsp.used) begin
                     corrupt_ff <= 1'b1;
                  end
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_RL_FETCH;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   ismap_bitmap u_bitmap (
      .clock      (clock),
      .reset      (reset),
      .cmd        (bm_cmd_ff),
      .rsp        (bm_rsp),
      .free_count (free_count)
   );

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_sector       = rsp_sector_ff;
   assign rsp_file_bytes   = length_ff;
   assign rsp_used_sectors = mapped_ff;

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("core: back-to-back result beats");
   a_mapped_range: assert property (@(posedge clock) disable iff (reset)
      mapped_ff <= ismap_pkg::COUNT_W'(ismap_pkg::MAX_SECTORS))
      else $error("core: mapped count beyond capacity");
   a_sector_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ismap_pkg::ST_OK)) |-> (rsp_sector == '0))
      else $error("core: sector on a failed result");

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
module testbench;

   typedef struct packed {
      logic [ismap_pkg::STATUS_W-1:0] status;
      logic [ismap_pkg::SECTOR_W-1:0] sector;
      logic [ismap_pkg::BYTES_W-1:0]  file_bytes;
      logic [ismap_pkg::COUNT_W-1:0]  used_sectors;
   } map_result_type;

   typedef struct packed {
      logic [ismap_pkg::FUNC_W-1:0]  func;
      logic [ismap_pkg::BYTES_W-1:0] byte_count;
      logic [ismap_pkg::COUNT_W-1:0] sector_count;
      logic [ismap_pkg::BYTES_W-1:0] byte_offset;
      logic                          fixed;
      map_result_type                res;
   } op_row_type;

   logic clock, reset, start, busy;
   logic [ismap_pkg::FUNC_W-1:0]   req_func;
   logic [ismap_pkg::BYTES_W-1:0]  req_byte_count;
   logic [ismap_pkg::COUNT_W-1:0]  req_sector_count;
   logic [ismap_pkg::BYTES_W-1:0]  req_byte_offset;
   logic                           rsp_valid;
   logic [ismap_pkg::STATUS_W-1:0] rsp_status;
   logic [ismap_pkg::SECTOR_W-1:0] rsp_sector;
   logic [ismap_pkg::BYTES_W-1:0]  rsp_file_bytes;
   logic [ismap_pkg::COUNT_W-1:0]  rsp_used_sectors;

   inode_sector_map_engine_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_byte_count(req_byte_count),
      .req_sector_count(req_sector_count), .req_byte_offset(req_byte_offset),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_sector(rsp_sector),
      .rsp_file_bytes(rsp_file_bytes), .rsp_used_sectors(rsp_used_sectors)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #20000000;
      $display("TB_ERROR");
      $finish;
   end

   // shadow copy of the file map
   logic [ismap_pkg::SECTOR_W-1:0] sh_direct [ismap_pkg::DIRECT_SLOTS];
   logic [ismap_pkg::SECTOR_W-1:0] sh_ptr [ismap_pkg::INDEX_BLOCKS];
   logic [ismap_pkg::SECTOR_W-1:0] sh_entry [ismap_pkg::INDEX_BLOCKS*ismap_pkg::ENTRIES_PER_INDEX];
   bit                             sh_used_bm [ismap_pkg::DISK_SECTORS];
   int unsigned                    sh_mapped, sh_len;

   map_result_type expected_results[$];
   logic           fixed_q[$];
   map_result_type fixed_res_q[$];
   int             errors, n_checked;
   int             status_seen [8];
   bit             gaps_on;

   function automatic int unsigned idx_blocks(int unsigned n);
      if (n <= ismap_pkg::DIRECT_SLOTS) return 0;
      return (n - ismap_pkg::DIRECT_SLOTS + ismap_pkg::ENTRIES_PER_INDEX - 1)
             / ismap_pkg::ENTRIES_PER_INDEX;
   endfunction

   function automatic int unsigned free_sectors();
      int unsigned c;
      c = 0;
      for (int i = 0; i < ismap_pkg::DISK_SECTORS; i++) if (!sh_used_bm[i]) c++;
      return c;
   endfunction

   function automatic logic [ismap_pkg::SECTOR_W-1:0] grab_sector();
      for (int i = 0; i < ismap_pkg::DISK_SECTORS; i++) begin
         if (!sh_used_bm[i]) begin
            sh_used_bm[i] = 1'b1;
            return ismap_pkg::SECTOR_W'(i);
         end
      end
      return '0;
   endfunction

   function automatic void append_one();
      int unsigned r;
      if (sh_mapped < ismap_pkg::DIRECT_SLOTS) begin
         sh_direct[sh_mapped] = grab_sector();
      end else begin
         r = sh_mapped - ismap_pkg::DIRECT_SLOTS;
         if (r >= ismap_pkg::INDEX_BLOCKS*ismap_pkg::ENTRIES_PER_INDEX) return;
         if (r % ismap_pkg::ENTRIES_PER_INDEX == 0)
            sh_ptr[r / ismap_pkg::ENTRIES_PER_INDEX] = grab_sector();
         sh_entry[r] = grab_sector();
      end
      sh_mapped++;
   endfunction

   function automatic logic [ismap_pkg::SECTOR_W-1:0] lookup(int unsigned m);
      if (m < ismap_pkg::DIRECT_SLOTS) return sh_direct[m];
      return sh_entry[m - ismap_pkg::DIRECT_SLOTS];
   endfunction

   function automatic map_result_type map_predict(logic [ismap_pkg::FUNC_W-1:0] f,
                                                  int unsigned bytes, int unsigned add,
                                                  int unsigned offset);
      map_result_type r;
      int unsigned n, nb;
      bit ok;
      r = '0;
      r.status = ismap_pkg::ST_OK;
      case (f)
         ismap_pkg::FN_ALLOCATE: begin
            n = (bytes + ismap_pkg::SECTOR_BYTES - 1) / ismap_pkg::SECTOR_BYTES;
            if (bytes > ismap_pkg::MAX_BYTES) r.status = ismap_pkg::ST_TOO_LARGE;
            else if (free_sectors() < n + idx_blocks(n)) r.status = ismap_pkg::ST_NO_SPACE;
            else begin
               sh_mapped = 0;
               for (int i = 0; i < n; i++) append_one();
               sh_len = bytes;
            end
         end
         ismap_pkg::FN_EXTEND: begin
            if (bytes > ismap_pkg::MAX_BYTES) r.status = ismap_pkg::ST_TOO_LARGE;
            else if (sh_mapped + add > ismap_pkg::MAX_SECTORS) r.status = ismap_pkg::ST_NO_SPACE;
            else if (free_sectors() <
                     add + idx_blocks(sh_mapped + add) - idx_blocks(sh_mapped))
               r.status = ismap_pkg::ST_NO_SPACE;
            else begin
               for (int i = 0; i < add; i++) append_one();
               sh_len = bytes;
            end
         end
         ismap_pkg::FN_RELEASE: begin
            nb = idx_blocks(sh_mapped);
            ok = 1'b1;
            for (int i = 0; i < sh_mapped; i++) if (!sh_used_bm[lookup(i)]) ok = 1'b0;
            for (int i = 0; i < nb; i++) if (!sh_used_bm[sh_ptr[i]]) ok = 1'b0;
            if (!ok) r.status = ismap_pkg::ST_CORRUPT;
            else begin
               for (int i = 0; i < sh_mapped; i++) sh_used_bm[lookup(i)] = 1'b0;
               for (int i = 0; i < nb; i++) sh_used_bm[sh_ptr[i]] = 1'b0;
               sh_mapped = 0;
               sh_len = 0;
            end
         end
         default: begin
            if (offset >= sh_len || offset / ismap_pkg::SECTOR_BYTES >= sh_mapped)
               r.status = ismap_pkg::ST_OUT_OF_RANGE;
            else r.sector = lookup(offset / ismap_pkg::SECTOR_BYTES);
         end
      endcase
      r.file_bytes = ismap_pkg::BYTES_W'(sh_len);
      r.used_sectors = ismap_pkg::COUNT_W'(sh_mapped);
      return r;
   endfunction

   // check first, then take any beat accepted at this edge
   always @(posedge clock) begin
      map_result_type e, p;
      logic fx;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result status %0d", $realtime, rsp_status);
            errors++;
         end else begin
            e = expected_results.pop_front();
            n_checked++;
            if (rsp_status !== e.status) begin
               $display("%0t: status exp %0d got %0d", $realtime, e.status, rsp_status);
               errors++;
            end
            if (rsp_sector !== e.sector) begin
               $display("%0t: sector exp %0d got %0d", $realtime, e.sector, rsp_sector);
               errors++;
            end
            if (rsp_file_bytes !== e.file_bytes) begin
               $display("%0t: file_bytes exp %0d got %0d", $realtime, e.file_bytes,
                        rsp_file_bytes);
               errors++;
            end
            if (rsp_used_sectors !== e.used_sectors) begin
               $display("%0t: used_sectors exp %0d got %0d", $realtime, e.used_sectors,
                        rsp_used_sectors);
               errors++;
            end
         end
      end
      if (!reset && start && !busy) begin
         p = map_predict(req_func, 32'(req_byte_count), 32'(req_sector_count),
                         32'(req_byte_offset));
         status_seen[p.status]++;
         fx = fixed_q.pop_front();
         e = fixed_res_q.pop_front();
         expected_results.push_back(fx ? e : p);
      end
   end

   task automatic issue(op_row_type row);
      int g, k;
      fixed_q.push_back(row.fixed);
      fixed_res_q.push_back(row.res);
      req_func <= row.func;
      req_byte_count <= row.byte_count;
      req_sector_count <= row.sector_count;
      req_byte_offset <= row.byte_offset;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      k = $urandom_range(99);
      g = !gaps_on ? 0 : (k < 55) ? 0 : (k < 90) ? $urandom_range(1, 3)
                                                 : $urandom_range(8, 60);
      if (g > 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   function automatic op_row_type mk(logic [ismap_pkg::FUNC_W-1:0] f, int unsigned b,
                                     int unsigned c, int unsigned o);
      op_row_type r;
      r = '0;
      r.func = f;
      r.byte_count = ismap_pkg::BYTES_W'(b);
      r.sector_count = ismap_pkg::COUNT_W'(c);
      r.byte_offset = ismap_pkg::BYTES_W'(o);
      return r;
   endfunction

   function automatic op_row_type mkx(logic [ismap_pkg::FUNC_W-1:0] f, int unsigned b,
                                      int unsigned c, int unsigned o,
                                      logic [ismap_pkg::STATUS_W-1:0] s,
                                      int unsigned sec, int unsigned fb, int unsigned u);
      op_row_type r;
      r = mk(f, b, c, o);
      r.fixed = 1'b1;
      r.res.status = s;
      r.res.sector = ismap_pkg::SECTOR_W'(sec);
      r.res.file_bytes = ismap_pkg::BYTES_W'(fb);
      r.res.used_sectors = ismap_pkg::COUNT_W'(u);
      return r;
   endfunction

   op_row_type directed[$];

   initial begin
      op_row_type row;
      int k, cnt;
      int unsigned b, c, o;
      errors = 0;
      n_checked = 0;
      gaps_on = 1'b1;
      sh_mapped = 0;
      sh_len = 0;
      foreach (sh_used_bm[i]) sh_used_bm[i] = 1'b0;
      foreach (sh_direct[i]) sh_direct[i] = '0;
      foreach (sh_ptr[i]) sh_ptr[i] = '0;
      foreach (sh_entry[i]) sh_entry[i] = '0;
      reset <= 1'b1;
      start <= 1'b0;
      req_func <= ismap_pkg::FN_ALLOCATE;
      req_byte_count <= '0;
      req_sector_count <= '0;
      req_byte_offset <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed = '{
         mkx(ismap_pkg::FN_TRANSLATE, 0, 0, 0, ismap_pkg::ST_OUT_OF_RANGE, 0, 0, 0),
         mkx(ismap_pkg::FN_RELEASE, 0, 0, 0, ismap_pkg::ST_OK, 0, 0, 0),
         mkx(ismap_pkg::FN_ALLOCATE, ismap_pkg::MAX_BYTES + 1, 0, 0,
             ismap_pkg::ST_TOO_LARGE, 0, 0, 0),
         mkx(ismap_pkg::FN_EXTEND, 32767, 255, 32767, ismap_pkg::ST_TOO_LARGE, 0, 0, 0),
         mkx(ismap_pkg::FN_ALLOCATE, 0, 0, 0, ismap_pkg::ST_OK, 0, 0, 0),
         mkx(ismap_pkg::FN_ALLOCATE, ismap_pkg::MAX_BYTES, 0, 0, ismap_pkg::ST_OK, 0,
             ismap_pkg::MAX_BYTES, ismap_pkg::MAX_SECTORS),
         mkx(ismap_pkg::FN_TRANSLATE, 0, 0, 0, ismap_pkg::ST_OK, 0,
             ismap_pkg::MAX_BYTES, ismap_pkg::MAX_SECTORS),
         mk(ismap_pkg::FN_TRANSLATE, 0, 0, ismap_pkg::MAX_BYTES - 1),
         mkx(ismap_pkg::FN_TRANSLATE, 0, 0, ismap_pkg::MAX_BYTES, ismap_pkg::ST_OUT_OF_RANGE,
             0, ismap_pkg::MAX_BYTES, ismap_pkg::MAX_SECTORS),
         mkx(ismap_pkg::FN_EXTEND, ismap_pkg::MAX_BYTES, 1, 0, ismap_pkg::ST_NO_SPACE, 0,
             ismap_pkg::MAX_BYTES, ismap_pkg::MAX_SECTORS),
         mkx(ismap_pkg::FN_EXTEND, 0, 255, 0, ismap_pkg::ST_NO_SPACE, 0,
             ismap_pkg::MAX_BYTES, ismap_pkg::MAX_SECTORS),
         mkx(ismap_pkg::FN_RELEASE, 0, 0, 0, ismap_pkg::ST_OK, 0, 0, 0),
         mkx(ismap_pkg::FN_ALLOCATE, 1, 0, 0, ismap_pkg::ST_OK, 0, 1, 1),
         mk(ismap_pkg::FN_EXTEND, 1100, 8, 0),
         mk(ismap_pkg::FN_EXTEND, 5000, 0, 0),
         mk(ismap_pkg::FN_TRANSLATE, 0, 0, 4999),
         mk(ismap_pkg::FN_TRANSLATE, 0, 0, 1099),
         mk(ismap_pkg::FN_ALLOCATE, 1000, 0, 0),
         mk(ismap_pkg::FN_RELEASE, 0, 0, 0),
         mk(ismap_pkg::FN_ALLOCATE, 1025, 0, 0),
         mk(ismap_pkg::FN_EXTEND, 5120, 31, 0),
         mk(ismap_pkg::FN_TRANSLATE, 0, 0, 5119),
         mk(ismap_pkg::FN_EXTEND, 5120, 0, 0),
         mk(ismap_pkg::FN_RELEASE, 0, 0, 0)
      };
      foreach (directed[i]) issue(directed[i]);

      for (int n = 0; n < 1800; n++) begin
         if (n % 150 == 0) gaps_on = ($urandom_range(3) != 0);
         k = $urandom_range(99);
         if (k < 5) begin
            row = mk(ismap_pkg::FUNC_W'($urandom_range(3)), $urandom_range(32767),
                     $urandom_range(255), $urandom_range(32767));
         end else if (k < 40) begin
            o = ($urandom_range(9) < 8) ? $urandom_range(sh_len) : $urandom_range(32767);
            row = mk(ismap_pkg::FN_TRANSLATE, $urandom_range(32767), $urandom_range(255), o);
         end else if (k < 65) begin
            c = ($urandom_range(9) < 8) ? $urandom_range(20) : $urandom_range(255);
            b = (sh_mapped + c) * ismap_pkg::SECTOR_BYTES;
            b = (b > 127) ? b - $urandom_range(127) : b;
            if ($urandom_range(9) == 0) b = $urandom_range(32767);
            row = mk(ismap_pkg::FN_EXTEND, b, c, $urandom_range(32767));
         end else if (k < 78) begin
            row = mk(ismap_pkg::FN_RELEASE, $urandom_range(32767), $urandom_range(255),
                     $urandom_range(32767));
         end else begin
            if (sh_mapped != 0 && !($urandom_range(99) < 3 && free_sectors() > 500)) begin
               issue(mk(ismap_pkg::FN_RELEASE, 0, 0, 0));
               n++;
            end
            c = $urandom_range(99);
            b = (c < 88) ? $urandom_range(2048)
              : (c < 96) ? $urandom_range(ismap_pkg::MAX_BYTES) : $urandom_range(32767);
            row = mk(ismap_pkg::FN_ALLOCATE, b, $urandom_range(255), $urandom_range(32767));
         end
         issue(row);
      end

      // leak full-size files until the bitmap runs dry
      gaps_on = 1'b1;
      for (int n = 0; n < 9; n++) issue(mk(ismap_pkg::FN_ALLOCATE, ismap_pkg::MAX_BYTES, 0, 0));
      issue(mk(ismap_pkg::FN_TRANSLATE, 0, 0, 200));
      issue(mk(ismap_pkg::FN_RELEASE, 0, 0, 0));
      issue(mk(ismap_pkg::FN_ALLOCATE, 2048, 0, 0));
      issue(mk(ismap_pkg::FN_EXTEND, 2048 + 40 * ismap_pkg::SECTOR_BYTES, 40, 0));
      start <= 1'b0;

      cnt = 0;
      while (expected_results.size() != 0 && cnt < 200000) begin
         @(posedge clock);
         cnt++;
      end
      repeat (64) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $realtime, expected_results.size());
         errors++;
      end
      $display("checked %0d results: ok %0d, no_space %0d, too_large %0d,",
               n_checked, status_seen[ismap_pkg::ST_OK], status_seen[ismap_pkg::ST_NO_SPACE],
               status_seen[ismap_pkg::ST_TOO_LARGE]);
      $display("corrupt %0d, out_of_range %0d; %0d errors",
               status_seen[ismap_pkg::ST_CORRUPT], status_seen[ismap_pkg::ST_OUT_OF_RANGE],
               errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
